// ===== sv/dga_pkg.sv =====
// Shared types and constants for the distance gain attenuator.
package dga_pkg;

  localparam int DIST_W = 22;
  localparam int VOL_W  = 16;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_SOURCE_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_Z      = 3'd2;
  localparam logic [IDX_W-1:0] REG_AUDIBLE_RANGE = 3'd3;
  localparam logic [IDX_W-1:0] REG_FULL_RADIUS   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BASE_VOLUME   = 3'd5;

  // Which gain source a beat takes at the end of the pipeline.
  typedef enum logic [1:0] {
    SEL_VOL,
    SEL_ZERO,
    SEL_DIV
  } gain_sel_t;

endpackage

// ===== sv/dga_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded down.
module dga_sqrt
  import dga_pkg::*;
#(
  parameter int IN_W = 52
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [IN_W-1:0]          radicand,
  output logic                     out_valid,
  output logic [(IN_W+1)/2-1:0]    root
);

  localparam int RW = (IN_W + 1) / 2;
  localparam int W2 = 2 * RW;

  logic [W2-1:0] n_q   [RW+1];
  logic [W2-1:0] res_q [RW+1];
  logic          vld_q [RW+1];

  assign n_q[0]   = W2'(radicand);
  assign res_q[0] = '0;
  assign vld_q[0] = in_valid;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [W2-1:0] BIT = W2'(1) << (2 * (RW - 1 - k));
    logic [W2:0]   trial;
    logic [W2-1:0] n_next;
    logic [W2-1:0] res_next;

    always_comb begin
      trial = {1'b0, res_q[k]} + {1'b0, BIT};
      if ({1'b0, n_q[k]} >= trial) begin
        n_next   = n_q[k] - trial[W2-1:0];
        res_next = (res_q[k] >> 1) + BIT;
      end else begin
        n_next   = n_q[k];
        res_next = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      n_q[k+1]   <= n_next;
      res_q[k+1] <= res_next;
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = res_q[RW][RW-1:0];

endmodule

// ===== sv/dga_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a gain select tag.
module dga_div
  import dga_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  gain_sel_t                 in_sel,
  input  logic [VOL_W+DIST_W-1:0]   numer,
  input  logic [DIST_W-1:0]         denom,
  output logic                      out_valid,
  output gain_sel_t                 out_sel,
  output logic [VOL_W-1:0]          quot
);

  localparam int QW = VOL_W;
  localparam int NW = VOL_W + DIST_W;

  // The quotient is known to stay below the volume, so QW bits suffice.
  logic [NW-1:0] r_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  gain_sel_t     sel_q [QW+1];
  logic          vld_q [QW+1];

  assign r_q[0]   = numer;
  assign q_q[0]   = '0;
  assign sel_q[0] = in_sel;
  assign vld_q[0] = in_valid;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [NW-1:0] dsh;
    logic [NW-1:0] r_next;
    logic [QW-1:0] q_next;

    always_comb begin
      dsh    = NW'(denom) << SH;
      r_next = r_q[j];
      q_next = q_q[j];
      if (r_q[j] >= dsh) begin
        r_next     = r_q[j] - dsh;
        q_next[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      r_q[j+1]   <= r_next;
      q_q[j+1]   <= q_next;
      sel_q[j+1] <= sel_q[j];
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end
  end

  assign out_valid = vld_q[QW];
  assign out_sel   = sel_q[QW];
  assign quot      = q_q[QW];

endmodule

// ===== sv/distance_gain_attenuator_core.sv =====
// Top level of the distance gain attenuator: clamped linear gain from listener distance.
// The pipeline holds difference, square and sum stages, RW = (SW + 1) / 2 square root
//   stages (26 at the default 24-bit coordinates), compare, multiply, divider and output.
// Throughput: one beat per cycle; the square root and divider run one bit per stage.
// Reset: synchronous, active high; clears in-flight beats and restores register defaults
//   (base volume unity, all else zero). busy is high only in reset; done is a strobe.
module distance_gain_attenuator_core
  import dga_pkg::*;
#(
  parameter int COORD_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 15
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [COORD_WIDTH-1:0]             listener_x,
  input  logic signed [COORD_WIDTH-1:0]             listener_y,
  input  logic signed [COORD_WIDTH-1:0]             listener_z,
  output logic                                      done,
  output logic [VOL_W-1:0]                          gain,
  input  logic                                      cfg_we,
  input  logic [IDX_W-1:0]                          cfg_index,
  input  logic [(COORD_WIDTH > DIST_W ? COORD_WIDTH : DIST_W)-1:0] cfg_data
);

  // Width bookkeeping. Magnitudes of per-axis differences are clamped to 32 bits, and the
  // sum of squares to 64 bits; both clamps only bite at the widest coordinates.
  localparam int MAGW = COORD_WIDTH + 1;
  localparam int MW   = (MAGW > 32) ? 32 : MAGW;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int SW   = (SUMW > 64) ? 64 : SUMW;
  localparam int RW   = (SW + 1) / 2;
  localparam int CW   = (RW > DIST_W) ? RW : DIST_W;
  localparam int LAT  = RW + 22;
  localparam logic [VOL_W-1:0] UNITY =
    (GAIN_FRAC_BITS >= VOL_W) ? {VOL_W{1'b1}} : VOL_W'(1 << GAIN_FRAC_BITS);

  // Configuration registers.
  logic [COORD_WIDTH-1:0] source_x, source_y, source_z;
  logic [DIST_W-1:0]      audible_range, full_radius;
  logic [VOL_W-1:0]       base_volume;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x      <= '0;
      source_y      <= '0;
      source_z      <= '0;
      audible_range <= '0;
      full_radius   <= '0;
      base_volume   <= UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_X:      source_x      <= cfg_data[COORD_WIDTH-1:0];
        REG_SOURCE_Y:      source_y      <= cfg_data[COORD_WIDTH-1:0];
        REG_SOURCE_Z:      source_z      <= cfg_data[COORD_WIDTH-1:0];
        REG_AUDIBLE_RANGE: audible_range <= cfg_data[DIST_W-1:0];
        REG_FULL_RADIUS:   full_radius   <= cfg_data[DIST_W-1:0];
        REG_BASE_VOLUME:   base_volume   <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // The user must change registers only while the pipeline is empty (unenforced); every stage reads them directly.
  logic [VOL_W-1:0]  vol;
  logic [DIST_W-1:0] slope_den;
  assign vol       = (base_volume > UNITY) ? UNITY : base_volume;
  assign slope_den = audible_range - full_radius;

  assign busy = rst;

  // Stage 1: per-axis absolute difference, clamped.
  function automatic logic [MW-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                             input logic [COORD_WIDTH-1:0] b);
    logic signed [MAGW-1:0] df;
    logic [MAGW-1:0]        mag;
    df  = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    mag = df[MAGW-1] ? MAGW'(-df) : MAGW'(df);
    if ((mag >> MW) != '0) begin
      return '1;
    end
    return mag[MW-1:0];
  endfunction

  logic          s1_vld;
  logic [MW-1:0] mag_x, mag_y, mag_z;

  always_ff @(posedge clk) begin
    mag_x <= abs_diff(listener_x, source_x);
    mag_y <= abs_diff(listener_y, source_y);
    mag_z <= abs_diff(listener_z, source_z);
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  // Stage 2: squares, one multiplier per axis.
  logic           s2_vld;
  logic [SQW-1:0] sq_x, sq_y, sq_z;

  always_ff @(posedge clk) begin
    sq_x <= SQW'(mag_x) * SQW'(mag_x);
    sq_y <= SQW'(mag_y) * SQW'(mag_y);
    sq_z <= SQW'(mag_z) * SQW'(mag_z);
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  // Stage 3: saturating sum of squares.
  logic            s3_vld;
  logic [SW-1:0]   sum_sq;
  logic [SUMW-1:0] sum_full;

  assign sum_full = SUMW'(sq_x) + SUMW'(sq_y) + SUMW'(sq_z);

  always_ff @(posedge clk) begin
    sum_sq <= ((sum_full >> SW) != '0) ? '1 : sum_full[SW-1:0];
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  // Distance through the pipelined square root.
  logic          rt_vld;
  logic [RW-1:0] root_dist;

  dga_sqrt #(
    .IN_W (SW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_vld),
    .radicand  (sum_sq),
    .out_valid (rt_vld),
    .root      (root_dist)
  );

  // Compare stage: choose full volume, silence, or the linear slope.
  logic              cmp_vld;
  gain_sel_t         cmp_sel;
  logic [DIST_W-1:0] cmp_rem;
  logic [CW-1:0]     dist_ext;

  assign dist_ext = CW'(root_dist);

  always_ff @(posedge clk) begin
    cmp_rem <= audible_range - dist_ext[DIST_W-1:0];
    if (dist_ext <= CW'(full_radius)) begin
      cmp_sel <= SEL_VOL;
    end else if (audible_range <= full_radius || dist_ext >= CW'(audible_range)) begin
      cmp_sel <= SEL_ZERO;
    end else begin
      cmp_sel <= SEL_DIV;
    end
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= rt_vld;
    end
  end

  // Multiply stage: volume times the distance left to the range.
  logic                    mul_vld;
  gain_sel_t               mul_sel;
  logic [VOL_W+DIST_W-1:0] mul_num;

  always_ff @(posedge clk) begin
    mul_num <= (VOL_W + DIST_W)'(vol) * (VOL_W + DIST_W)'(cmp_rem);
    mul_sel <= cmp_sel;
    if (rst) begin
      mul_vld <= 1'b0;
    end else begin
      mul_vld <= cmp_vld;
    end
  end

  logic             div_vld;
  gain_sel_t        div_sel;
  logic [VOL_W-1:0] div_quot;

  dga_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_vld),
    .in_sel    (mul_sel),
    .numer     (mul_num),
    .denom     (slope_den),
    .out_valid (div_vld),
    .out_sel   (div_sel),
    .quot      (div_quot)
  );

  // Output register. A zero range means room-wide playback at the clamped base volume.
  always_ff @(posedge clk) begin
    if (audible_range == '0) begin
      gain <= vol;
    end else begin
      case (div_sel)
        SEL_VOL:  gain <= vol;
        SEL_ZERO: gain <= '0;
        SEL_DIV:  gain <= div_quot;
        default:  gain <= '0;
      endcase
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld;
    end
  end

`ifndef SYNTH
  // Every accepted beat comes out as a done strobe at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted beat did not complete after the pipeline latency");

  // The gain never exceeds unity when done is high.
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (gain <= UNITY))
    else $error("gain above unity");

  // Room-wide playback returns the clamped base volume.
  a_room_wide: assert property (@(posedge clk) disable iff (rst)
    (done && audible_range == '0) |-> (gain == vol))
    else $error("room-wide gain differs from base volume");
`endif

endmodule
